FILE: rtl/filled_triangle_scan_converter_defines.svh
// assertion macros used by the scan converter back end
`ifndef FILLED_TRIANGLE_SCAN_CONVERTER_DEFINES_SVH
`define FILLED_TRIANGLE_SCAN_CONVERTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FTSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scan converter check failed");

// next-cycle implication, checked out of reset
`define FTSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scan converter check failed");

`endif

FILE: rtl/ftsc_pkg.sv
// shared types and constants of the triangle scan converter
package ftsc_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam int   CHAN_W   = 8;
  localparam int   COLOUR_W = 3 * CHAN_W;

  typedef struct packed {
    logic valid;
    logic is_load;
  } qstat_t;

  typedef enum logic [4:0] {
    S_WAIT = 5'b00001,
    S_MUL  = 5'b00010,
    S_HALF = 5'b00100,
    S_SPAN = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    JOB_SPLIT,
    JOB_EDGE_L,
    JOB_EDGE_R,
    JOB_SPAN
  } job_t;

endpackage

FILE: rtl/filled_triangle_scan_converter.sv
// top level of the filled triangle scan converter
//
//  channel  | handshake       | fields
//  ---------+-----------------+------------------------------------------------
//  input    | push / full     | in_req_type, in_vert0..2_x/y, in_red/green/blue
//  result   | empty / pop     | out_pixel_valid/x/y, out_colour_code, out_last_pixel
//
// a pixel beat needs no division while the current row runs; starting a row costs one
// span division, a new half both edge divisions and a span division, a load a multiply
// and a split division; each division holds the back end on the one shared divider
// until it is done.
// a two-entry request queue lets input beats land while the back end divides or
// the result register waits; reset is synchronous and empties both sides.
module filled_triangle_scan_converter #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_req_type,
  input  logic [COORD_BITS-1:0]         in_vert0_x,
  input  logic [COORD_BITS-1:0]         in_vert0_y,
  input  logic [COORD_BITS-1:0]         in_vert1_x,
  input  logic [COORD_BITS-1:0]         in_vert1_y,
  input  logic [COORD_BITS-1:0]         in_vert2_x,
  input  logic [COORD_BITS-1:0]         in_vert2_y,
  input  logic [ftsc_pkg::CHAN_W-1:0]   in_red,
  input  logic [ftsc_pkg::CHAN_W-1:0]   in_green,
  input  logic [ftsc_pkg::CHAN_W-1:0]   in_blue,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_pixel_valid,
  output logic [COORD_BITS-1:0]         out_pixel_x,
  output logic [COORD_BITS-1:0]         out_pixel_y,
  output logic [ftsc_pkg::COLOUR_W-1:0] out_colour_code,
  output logic                          out_last_pixel
);

  ftsc_pkg::qstat_t q_stat;
  logic             q_pop;
  logic [6*COORD_BITS+ftsc_pkg::COLOUR_W-1:0] q_item;

  ftsc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_vert0_x  (in_vert0_x),
    .in_vert0_y  (in_vert0_y),
    .in_vert1_x  (in_vert1_x),
    .in_vert1_y  (in_vert1_y),
    .in_vert2_x  (in_vert2_x),
    .in_vert2_y  (in_vert2_y),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .q_pop       (q_pop),
    .q_stat      (q_stat),
    .q_item      (q_item)
  );

  ftsc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_colour_code (out_colour_code),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

FILE: rtl/ftsc_front.sv
// front queue: takes requests, classifies them and buffers two
module ftsc_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_req_type,
  input  logic [COORD_BITS-1:0]      in_vert0_x,
  input  logic [COORD_BITS-1:0]      in_vert0_y,
  input  logic [COORD_BITS-1:0]      in_vert1_x,
  input  logic [COORD_BITS-1:0]      in_vert1_y,
  input  logic [COORD_BITS-1:0]      in_vert2_x,
  input  logic [COORD_BITS-1:0]      in_vert2_y,
  input  logic [ftsc_pkg::CHAN_W-1:0] in_red,
  input  logic [ftsc_pkg::CHAN_W-1:0] in_green,
  input  logic [ftsc_pkg::CHAN_W-1:0] in_blue,
  input  logic                       q_pop,
  output ftsc_pkg::qstat_t           q_stat,
  output logic [6*COORD_BITS+ftsc_pkg::COLOUR_W-1:0] q_item
);

  localparam int PW = 6 * COORD_BITS + ftsc_pkg::COLOUR_W;
  localparam int IW = PW + 1;

  logic [IW-1:0] mem_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wr, rd;
  logic [IW-1:0] head;

  assign full = (cnt_r == 2'd2);
  assign wr   = push && !full;
  assign rd   = q_pop && (cnt_r != 2'd0);
  assign head = mem_r[rp_r];

  assign q_stat.valid   = (cnt_r != 2'd0);
  assign q_stat.is_load = (head[IW-1] == ftsc_pkg::REQ_LOAD);
  assign q_item         = head[PW-1:0];

  always_comb begin
    wp_nxt  = wr ? !wp_r : wp_r;
    rp_nxt  = rd ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= {in_req_type, in_vert0_x, in_vert0_y, in_vert1_x, in_vert1_y,
                      in_vert2_x, in_vert2_y, in_red, in_green, in_blue};
    end
  end

endmodule

FILE: rtl/ftsc_div.sv
// shared restoring divider, one quotient bit a cycle, truncates toward zero
module ftsc_div #(
  parameter int NW = 36,
  parameter int DW = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW:0]   num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW:0]   quo
);

  localparam int CW = $clog2(NW + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [NW-1:0]      dvd_r, dvd_nxt;
  logic [DW:0]        rem_r, rem_nxt;
  logic [DW-1:0]      den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic signed [NW:0] quo_r, quo_nxt;
  logic [DW:0]        rem_sh;
  logic               qbit;
  logic [NW:0]        mag;
  logic [NW-1:0]      qfull;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    mag      = num[NW] ? (NW+1)'(0) - num : num;
    rem_sh   = {rem_r[DW-1:0], dvd_r[NW-1]};
    qbit     = (rem_sh >= {1'b0, den_r});
    qfull    = {dvd_r[NW-2:0], qbit};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      dvd_nxt  = mag[NW-1:0];
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[NW];
    end else if (busy_r) begin
      rem_nxt = qbit ? rem_sh - {1'b0, den_r} : rem_sh;
      dvd_nxt = qfull;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (den_r == '0) begin
          quo_nxt = '0;
        end else if (neg_r) begin
          quo_nxt = (NW+1)'(0) - $signed({1'b0, qfull});
        end else begin
          quo_nxt = $signed({1'b0, qfull});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

endmodule

FILE: rtl/ftsc_back.sv
// back end: triangle setup, edge and span walk, result register
`include "filled_triangle_scan_converter_defines.svh"

module ftsc_back #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ftsc_pkg::qstat_t              q_stat,
  input  logic [6*COORD_BITS+ftsc_pkg::COLOUR_W-1:0] q_item,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_pixel_valid,
  output logic [COORD_BITS-1:0]         out_pixel_x,
  output logic [COORD_BITS-1:0]         out_pixel_y,
  output logic [ftsc_pkg::COLOUR_W-1:0] out_colour_code,
  output logic                          out_last_pixel
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int XW = C + F + 2;
  localparam int NW = 2 * C + F;
  localparam int DW = C + 1;
  localparam int CL = ftsc_pkg::COLOUR_W;

  ftsc_pkg::state_t state_r, state_nxt;
  ftsc_pkg::job_t   job_r, job_nxt;

  logic                 busy_r, busy_nxt, half_r, half_nxt;
  logic [C-1:0]         tx_r, ty_r, mx_r, my_r, bx_r, by_r;
  logic [C-1:0]         tx_nxt, ty_nxt, mx_nxt, my_nxt, bx_nxt, by_nxt;
  logic signed [XW-1:0] split_r, split_nxt, el_r, el_nxt, er_r, er_nxt;
  logic signed [XW-1:0] sl_r, sl_nxt, sr_r, sr_nxt, step_r, step_nxt;
  logic signed [XW-1:0] pend_r, pend_nxt;
  logic [C-1:0]         row_r, row_nxt, h_r, h_nxt;
  logic [DW-1:0]        count_r, count_nxt, index_r, index_nxt;
  logic signed [XW:0]   acc_r, acc_nxt;
  logic [CL-1:0]        colour_r, colour_nxt;

  logic                 ov_r, ov_nxt, opv_r, opv_nxt, olast_r, olast_nxt;
  logic [C-1:0]         ox_r, ox_nxt, oy_r, oy_nxt;
  logic [CL-1:0]        oc_r, oc_nxt;

  logic                 div_start, div_done;
  logic signed [NW:0]   div_num, div_quo;
  logic [DW-1:0]        div_den;

  logic                 slot_free;
  logic signed [XW-1:0] txf, mxf, bxf, lx, rx, numl;
  logic signed [XW:0]   dx, rsum;
  logic [XW:0]          mag, csum;
  logic [XW-F:0]        rcol;
  logic [C-1:0]         pcol;
  logic signed [2*C+1:0] prod;
  logic signed [NW:0]   pnum;

  ftsc_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign empty           = !ov_r;
  assign out_pixel_valid = opv_r;
  assign out_pixel_x     = ox_r;
  assign out_pixel_y     = oy_r;
  assign out_colour_code = oc_r;
  assign out_last_pixel  = olast_r;

  assign slot_free = !ov_r || pop;

  // fixed-point vertex columns and the two ends of the middle row
  assign txf = $signed(XW'({tx_r, {F{1'b0}}}));
  assign mxf = $signed(XW'({mx_r, {F{1'b0}}}));
  assign bxf = $signed(XW'({bx_r, {F{1'b0}}}));
  assign lx  = (split_r < mxf) ? split_r : mxf;
  assign rx  = (split_r < mxf) ? mxf : split_r;

  // sample column, rounded half up and clamped
  assign rsum = acc_r + (XW+1)'(1 << (F - 1));
  assign rcol = rsum[XW:F];
  always_comb begin
    if (acc_r < 0) begin
      pcol = '0;
    end else if (rcol > (XW-F+1)'({C{1'b1}})) begin
      pcol = {C{1'b1}};
    end else begin
      pcol = rcol[C-1:0];
    end
  end

  assign prod = $signed({2'b00, my_r - ty_r}) * $signed({2'b00, bx_r} - {2'b00, tx_r});
  assign pnum = (NW+1)'(prod) <<< F;
  assign dx   = (XW+1)'(er_r) - (XW+1)'(el_r);
  assign mag  = dx[XW] ? (XW+1)'(0) - dx : dx;
  assign csum = mag + (XW+1)'((1 << F) - 1);

  always_comb begin
    logic [C-1:0] vx0, vy0, vx1, vy1, vx2, vy2, t;
    vx0 = q_item[CL+6*C-1 -: C];
    vy0 = q_item[CL+5*C-1 -: C];
    vx1 = q_item[CL+4*C-1 -: C];
    vy1 = q_item[CL+3*C-1 -: C];
    vx2 = q_item[CL+2*C-1 -: C];
    vy2 = q_item[CL+C-1 -: C];
    if (vy0 > vy1) begin
      t = vx0; vx0 = vx1; vx1 = t;
      t = vy0; vy0 = vy1; vy1 = t;
    end
    if (vy0 > vy2) begin
      t = vx0; vx0 = vx2; vx2 = t;
      t = vy0; vy0 = vy2; vy2 = t;
    end
    if (vy1 > vy2) begin
      t = vx1; vx1 = vx2; vx2 = t;
      t = vy1; vy1 = vy2; vy2 = t;
    end

    state_nxt  = state_r;
    job_nxt    = job_r;
    busy_nxt   = busy_r;
    half_nxt   = half_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    mx_nxt     = mx_r;
    my_nxt     = my_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    split_nxt  = split_r;
    el_nxt     = el_r;
    er_nxt     = er_r;
    sl_nxt     = sl_r;
    sr_nxt     = sr_r;
    step_nxt   = step_r;
    pend_nxt   = pend_r;
    row_nxt    = row_r;
    h_nxt      = h_r;
    count_nxt  = count_r;
    index_nxt  = index_r;
    acc_nxt    = acc_r;
    colour_nxt = colour_r;
    ov_nxt     = ov_r && !pop;
    opv_nxt    = opv_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oc_nxt     = oc_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    numl       = '0;

    unique case (state_r)
      ftsc_pkg::S_WAIT: begin
        if (q_stat.valid && q_stat.is_load) begin
          q_pop      = 1'b1;
          tx_nxt     = vx0;
          ty_nxt     = vy0;
          mx_nxt     = vx1;
          my_nxt     = vy1;
          bx_nxt     = vx2;
          by_nxt     = vy2;
          colour_nxt = q_item[CL-1:0];
          busy_nxt   = 1'b1;
          half_nxt   = 1'b0;
          state_nxt  = ftsc_pkg::S_MUL;
        end else if (q_stat.valid && slot_free) begin
          q_pop     = 1'b1;
          ov_nxt    = 1'b1;
          opv_nxt   = busy_r;
          ox_nxt    = busy_r ? pcol : '0;
          oy_nxt    = busy_r ? row_r : '0;
          oc_nxt    = busy_r ? colour_r : '0;
          olast_nxt = 1'b0;
          if (busy_r) begin
            if (index_r >= count_r) begin
              // row finished: step both edges
              el_nxt = el_r + sl_r;
              er_nxt = er_r + sr_r;
              if (!half_r) begin
                if (row_r >= my_r) begin
                  half_nxt  = 1'b1;
                  state_nxt = ftsc_pkg::S_HALF;
                end else begin
                  row_nxt   = row_r + C'(1);
                  state_nxt = ftsc_pkg::S_SPAN;
                end
              end else if (row_r >= by_r) begin
                busy_nxt  = 1'b0;
                olast_nxt = 1'b1;
              end else begin
                row_nxt   = row_r + C'(1);
                state_nxt = ftsc_pkg::S_SPAN;
              end
            end else begin
              index_nxt = index_r + DW'(1);
              acc_nxt   = acc_r + (XW+1)'(step_r);
            end
          end
        end
      end
      ftsc_pkg::S_MUL: begin
        div_start = 1'b1;
        div_num   = pnum;
        div_den   = DW'(by_r - ty_r);
        job_nxt   = ftsc_pkg::JOB_SPLIT;
        state_nxt = ftsc_pkg::S_DIV;
      end
      ftsc_pkg::S_HALF: begin
        if (!half_r) begin
          h_nxt    = my_r - ty_r;
          el_nxt   = txf;
          er_nxt   = txf;
          numl     = lx - txf;
          pend_nxt = rx - txf;
          row_nxt  = ty_r;
        end else begin
          h_nxt    = by_r - my_r;
          el_nxt   = lx;
          er_nxt   = rx;
          numl     = bxf - lx;
          pend_nxt = bxf - rx;
          row_nxt  = my_r;
        end
        div_start = 1'b1;
        div_num   = (NW+1)'(numl);
        div_den   = DW'(h_nxt);
        job_nxt   = ftsc_pkg::JOB_EDGE_L;
        state_nxt = ftsc_pkg::S_DIV;
      end
      ftsc_pkg::S_SPAN: begin
        count_nxt = DW'(csum >> F);
        div_start = 1'b1;
        div_num   = (NW+1)'(dx);
        div_den   = count_nxt;
        job_nxt   = ftsc_pkg::JOB_SPAN;
        state_nxt = ftsc_pkg::S_DIV;
      end
      ftsc_pkg::S_DIV: begin
        if (div_done) begin
          case (job_r)
            ftsc_pkg::JOB_SPLIT: begin
              split_nxt = txf + XW'(div_quo);
              state_nxt = ftsc_pkg::S_HALF;
            end
            ftsc_pkg::JOB_EDGE_L: begin
              sl_nxt    = XW'(div_quo);
              div_start = 1'b1;
              div_num   = (NW+1)'(pend_r);
              div_den   = DW'(h_r);
              job_nxt   = ftsc_pkg::JOB_EDGE_R;
            end
            ftsc_pkg::JOB_EDGE_R: begin
              sr_nxt    = XW'(div_quo);
              state_nxt = ftsc_pkg::S_SPAN;
            end
            default: begin
              step_nxt  = XW'(div_quo);
              index_nxt = '0;
              acc_nxt   = (XW+1)'(el_r);
              state_nxt = ftsc_pkg::S_WAIT;
            end
          endcase
        end
      end
      default: state_nxt = ftsc_pkg::S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftsc_pkg::S_WAIT;
      busy_r  <= 1'b0;
      half_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      half_r  <= half_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    bx_r     <= bx_nxt;
    by_r     <= by_nxt;
    split_r  <= split_nxt;
    el_r     <= el_nxt;
    er_r     <= er_nxt;
    sl_r     <= sl_nxt;
    sr_r     <= sr_nxt;
    step_r   <= step_nxt;
    pend_r   <= pend_nxt;
    row_r    <= row_nxt;
    h_r      <= h_nxt;
    count_r  <= count_nxt;
    index_r  <= index_nxt;
    acc_r    <= acc_nxt;
    colour_r <= colour_nxt;
    opv_r    <= opv_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oc_r     <= oc_nxt;
    olast_r  <= olast_nxt;
  end

  `FTSC_ASSERT_IMP(a_last_is_pixel, ov_r && olast_r, opv_r)
  `FTSC_ASSERT_IMP(a_idle_beat_zero, ov_r && !opv_r, ox_r == '0 && oy_r == '0 && oc_r == '0)
  `FTSC_ASSERT_IMP(a_pop_in_wait, q_pop, state_r == ftsc_pkg::S_WAIT)
  `FTSC_ASSERT_NXT(a_last_ends_busy, q_pop && !q_stat.is_load && olast_nxt, !busy_r)

endmodule
